@@ rtl/core/kcfs_pkg.sv @@
// Package for the keypad command frame sender: item and segment types,
// frame timing constants and the segment lookup function.
// No dependencies.
`timescale 1ns / 1ps

package kcfs_pkg;

  localparam int unsigned HoldWidth = 14;
  localparam int unsigned SegWidth  = 6;

  localparam logic [SegWidth-1:0] SegLast      = 6'd36;
  localparam logic [SegWidth-1:0] SegFirstBit  = 6'd7;
  localparam logic [SegWidth-1:0] SegLastBit   = 6'd30;

  localparam logic [HoldWidth-1:0] SettleUs    = 14'd10000;
  localparam logic [HoldWidth-1:0] RequestUs   = 14'd150;
  localparam logic [HoldWidth-1:0] BitUs       = 14'd20;
  localparam logic [HoldWidth-1:0] HighUs      = 14'd40;
  localparam logic [HoldWidth-1:0] StopHighUs  = 14'd30;
  localparam logic [HoldWidth-1:0] ReleaseUs   = 14'd0;

  localparam logic [1:0] PhaseHigh = 2'd1;
  localparam logic [1:0] PhaseLast = 2'd2;

  // Where the data line level of a segment comes from.
  typedef enum logic [1:0] {
    DataHigh,
    DataLow,
    DataBit,
    DataParity
  } data_sel_e;

  // One command as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] cmd;
    logic       parity;
  } item_t;

  typedef struct packed {
    logic                 clock;
    data_sel_e            data_sel;
    logic                 driven;
    logic [HoldWidth-1:0] hold;
  } seg_t;

  // Fixed shape of segment idx; the data-bit region uses the phase within
  // its three-segment bit cell.
  function automatic seg_t seg_lookup(input logic [SegWidth-1:0] idx,
                                      input logic [1:0] phase);
    seg_t s;
    s.clock    = 1'b0;
    s.data_sel = DataLow;
    s.driven   = 1'b1;
    s.hold     = BitUs;
    case (idx)
      6'd0: begin
        s.clock    = 1'b1;
        s.data_sel = DataHigh;
        s.hold     = SettleUs;
      end
      6'd1: begin
        s.data_sel = DataHigh;
      end
      6'd2: begin
        s.hold = RequestUs;
      end
      6'd3, 6'd4, 6'd6: begin
        s.data_sel = DataLow;
      end
      6'd5: begin
        s.clock = 1'b1;
      end
      6'd31, 6'd33: begin
        s.data_sel = DataParity;
      end
      6'd32: begin
        s.clock    = 1'b1;
        s.data_sel = DataParity;
      end
      6'd34: begin
        s.data_sel = DataHigh;
      end
      6'd35: begin
        s.clock    = 1'b1;
        s.data_sel = DataHigh;
        s.hold     = StopHighUs;
      end
      6'd36: begin
        s.clock    = 1'b1;
        s.data_sel = DataHigh;
        s.driven   = 1'b0;
        s.hold     = ReleaseUs;
      end
      default: begin
        s.data_sel = DataBit;
        s.clock    = (phase == PhaseHigh);
        s.hold     = (phase == PhaseHigh) ? HighUs : BitUs;
      end
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/kcfs_front.sv @@
// Front stage: takes command bytes, works out odd parity and registers the item.
// Depends on kcfs_pkg.
`timescale 1ns / 1ps

module kcfs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           command_byte_i,
  output logic                 item_valid_o,
  output kcfs_pkg::item_t      item_o,
  input  logic                 item_full_i
);
  import kcfs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  // The register frees itself whenever the queue behind it has room.
  assign full   = valid_q & item_full_i;
  assign accept = push & ~full;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d       = 1'b1;
      item_d.cmd    = command_byte_i;
      item_d.parity = ~(^command_byte_i);
    end else if (valid_q && !item_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/core/kcfs_queue.sv @@
// Two-entry queue that decouples the front stage from the segment sequencer.
// Depends on kcfs_pkg.
`timescale 1ns / 1ps

module kcfs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  kcfs_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            rd_i,
  output kcfs_pkg::item_t rd_item_o,
  output logic            empty_o
);
  import kcfs_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not follow a write");

endmodule

@@ rtl/core/kcfs_back.sv @@
// Segment sequencer: walks the 37 segments of a frame and holds each in an
// output register until it is popped. Depends on kcfs_pkg.
`timescale 1ns / 1ps

module kcfs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  kcfs_pkg::item_t      q_item_i,
  output logic                 q_rd_o,
  output logic                 empty,
  input  logic                 pop,
  output logic                 clock_level_o,
  output logic                 data_level_o,
  output logic                 lines_driven_o,
  output logic [13:0]          hold_us_o,
  output logic [5:0]           segment_index_o,
  output logic                 last_segment_o
);
  import kcfs_pkg::*;

  typedef enum logic {
    StIdle,
    StSend
  } state_e;

  state_e              state_q;
  logic [SegWidth-1:0] seg_q;
  logic [1:0]          phase_q;
  logic [7:0]          shift_q;
  logic                par_q;
  logic                out_valid_q;
  seg_t                seg;
  logic                advance, load_out, at_last, in_bits, data_bit;

  assign advance  = ~out_valid_q | pop;
  assign load_out = advance & (state_q == StSend);
  assign at_last  = (seg_q == SegLast);
  assign in_bits  = (seg_q >= SegFirstBit) && (seg_q <= SegLastBit);
  assign seg      = seg_lookup(seg_q, phase_q);
  assign q_rd_o   = ~q_empty_i & ((state_q == StIdle) | (load_out & at_last));
  assign empty    = ~out_valid_q;

  always_comb begin
    case (seg.data_sel)
      DataHigh:   data_bit = 1'b1;
      DataLow:    data_bit = 1'b0;
      DataBit:    data_bit = shift_q[0];
      DataParity: data_bit = par_q;
      default:    data_bit = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seg_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
      if (q_rd_o) begin
        state_q <= StSend;
        seg_q   <= '0;
        phase_q <= '0;
      end else if (load_out) begin
        if (at_last) begin
          state_q <= StIdle;
        end else begin
          seg_q <= seg_q + 6'd1;
          if (in_bits) begin
            phase_q <= (phase_q == PhaseLast) ? 2'd0 : phase_q + 2'd1;
          end
        end
      end
    end
  end

  // Payload: the command byte shifts out least significant bit first.
  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      shift_q <= q_item_i.cmd;
      par_q   <= q_item_i.parity;
    end else if (load_out && in_bits && phase_q == PhaseLast) begin
      shift_q <= {1'b0, shift_q[7:1]};
    end
    if (load_out) begin
      clock_level_o   <= seg.clock;
      data_level_o    <= data_bit;
      lines_driven_o  <= seg.driven;
      hold_us_o       <= seg.hold;
      segment_index_o <= seg_q;
      last_segment_o  <= at_last;
    end
  end

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_segment_o) |-> (segment_index_o == SegLast))
    else $error("last segment flag on wrong index");

  a_release_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !lines_driven_o) |-> last_segment_o)
    else $error("lines released before the frame end");

  a_seg_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !at_last && !q_rd_o) |=> (seg_q == $past(seg_q) + 6'd1))
    else $error("segment index skipped");

  a_phase_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSend && !in_bits) |-> (phase_q == 2'd0))
    else $error("bit phase out of step");

endmodule

@@ rtl/core/keypad_command_frame_sender.sv @@
// Path: a pushed byte passes the front register, the queue and the sequencer before its first segment is registered.
// Throughput: one beat of results per cycle while pop is held high and a byte
// is waiting; each byte gives 37 segments, walked by the segment sequencer.
// Up to four bytes (front register, two-entry queue, sequencer) may be held.
// Reset: asynchronous, active low; all queues empty, empty high, full low.
`timescale 1ns / 1ps

// Top level of the keypad command frame sender. It instantiates the front
// stage, the decoupling queue and the segment sequencer, all built on kcfs_pkg.
module keypad_command_frame_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input side, queue style: a beat moves when push is high and full is low.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  command_byte_i,
  // Result side, queue style: a beat moves when pop is high and empty is low.
  output logic        empty,
  input  logic        pop,
  output logic        clock_level_o,
  output logic        data_level_o,
  output logic        lines_driven_o,
  output logic [13:0] hold_us_o,
  output logic [5:0]  segment_index_o,
  output logic        last_segment_o
);
  import kcfs_pkg::*;

  // Items leave the front stage with their parity already worked out.
  logic  front_valid;
  item_t front_item;
  logic  q_full, q_empty, q_rd;
  item_t q_item;

  kcfs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_byte_i (command_byte_i),
    .item_valid_o   (front_valid),
    .item_o         (front_item),
    .item_full_i    (q_full)
  );

  // The queue lets the front keep taking bytes while a frame is still
  // being sent.
  kcfs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_item_i (front_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  // The sequencer picks up the next byte in the same cycle that it loads
  // the release segment of the current frame, so frames follow without a gap.
  kcfs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_item),
    .q_rd_o          (q_rd),
    .empty           (empty),
    .pop             (pop),
    .clock_level_o   (clock_level_o),
    .data_level_o    (data_level_o),
    .lines_driven_o  (lines_driven_o),
    .hold_us_o       (hold_us_o),
    .segment_index_o (segment_index_o),
    .last_segment_o  (last_segment_o)
  );

endmodule

@@ test/keypad_command_frame_sender_tb.sv @@
// Self-checking testbench for keypad_command_frame_sender: command bytes go in
// through the push/full side and every line segment is checked at the pop side.
// Depends on kcfs_pkg for the hold-time constants and field widths.
`timescale 1ns / 1ps

module keypad_command_frame_sender_tb;
  import kcfs_pkg::*;

  // One line segment as it should appear on the result ports.
  typedef struct {
    logic                 clock_level;
    logic                 data_level;
    logic                 lines_driven;
    logic [HoldWidth-1:0] hold_us;
    logic [SegWidth-1:0]  segment_index;
    logic                 last_segment;
  } line_seg_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 push           = 1'b0;
  logic [7:0]           command_byte_i = 8'h00;
  logic                 pop            = 1'b0;
  logic                 full;
  logic                 empty;
  logic                 clock_level_o;
  logic                 data_level_o;
  logic                 lines_driven_o;
  logic [HoldWidth-1:0] hold_us_o;
  logic [SegWidth-1:0]  segment_index_o;
  logic                 last_segment_o;

  // Segments still owed by the block, oldest first.
  line_seg_t expected_segments[$];
  int unsigned mismatches = 0;
  // While set, both sides insert random idle bursts; cleared for the last part.
  bit idling_enabled = 1'b1;

  keypad_command_frame_sender DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_byte_i  (command_byte_i),
    .empty           (empty),
    .pop             (pop),
    .clock_level_o   (clock_level_o),
    .data_level_o    (data_level_o),
    .lines_driven_o  (lines_driven_o),
    .hold_us_o       (hold_us_o),
    .segment_index_o (segment_index_o),
    .last_segment_o  (last_segment_o)
  );

  // 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Appends one segment to the list of outstanding results. The final release
  // segment is the only one flagged as last.
  function automatic void add_segment(input logic [SegWidth-1:0] idx, input logic clk_lvl,
                                      input logic dat_lvl, input logic drv,
                                      input logic [HoldWidth-1:0] hold);
    line_seg_t s;
    s.clock_level   = clk_lvl;
    s.data_level    = dat_lvl;
    s.lines_driven  = drv;
    s.hold_us       = hold;
    s.segment_index = idx;
    s.last_segment  = (idx == SegLast);
    expected_segments.push_back(s);
  endfunction

  // Works out the whole 37-segment frame for one command byte: settle, request
  // preamble, start pulse, eight data bits LSB first, odd parity, stop and
  // release. Each data bit cell is low-high-low on the clock line with the
  // longer hold on the high phase; the parity cell uses the short hold
  // throughout.
  function automatic void queue_frame(input logic [7:0] cmd);
    logic                parity;
    logic [SegWidth-1:0] base;
    int                  n;
    // Odd parity: set when the byte carries an even number of ones.
    parity = ~^cmd;
    add_segment(6'd0, 1'b1, 1'b1, 1'b1, SettleUs);
    add_segment(6'd1, 1'b0, 1'b1, 1'b1, BitUs);
    add_segment(6'd2, 1'b0, 1'b0, 1'b1, RequestUs);
    add_segment(6'd3, 1'b0, 1'b0, 1'b1, BitUs);
    add_segment(6'd4, 1'b0, 1'b0, 1'b1, BitUs);
    add_segment(6'd5, 1'b1, 1'b0, 1'b1, BitUs);
    add_segment(6'd6, 1'b0, 1'b0, 1'b1, BitUs);
    for (n = 0; n < 8; n++) begin
      base = 6'd7 + 6'(3 * n);
      add_segment(base,        1'b0, cmd[n], 1'b1, BitUs);
      add_segment(base + 6'd1, 1'b1, cmd[n], 1'b1, HighUs);
      add_segment(base + 6'd2, 1'b0, cmd[n], 1'b1, BitUs);
    end
    add_segment(6'd31, 1'b0, parity, 1'b1, BitUs);
    add_segment(6'd32, 1'b1, parity, 1'b1, BitUs);
    add_segment(6'd33, 1'b0, parity, 1'b1, BitUs);
    add_segment(6'd34, 1'b0, 1'b1, 1'b1, BitUs);
    add_segment(6'd35, 1'b1, 1'b1, 1'b1, StopHighUs);
    // Release: lines float back to their pulled-up idle level.
    add_segment(SegLast, 1'b1, 1'b1, 1'b0, ReleaseUs);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offers one command byte and returns once the beat has been taken. Inputs
  // only ever change at a rising edge; full is sampled at the falling edge, where
  // it is stable, so a high push with full low there means the following rising
  // edge accepts the beat.
  task automatic send_command(input logic [7:0] cmd);
    int gap;
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    command_byte_i <= cmd;
    forever begin
      @(negedge clk_i);
      if (!full) break;
    end
    @(posedge clk_i);
    queue_frame(cmd);
  endtask

  // Result side. Outputs are sampled at the falling edge, between updates, and
  // a beat counts as taken when pop is high and empty is low there. The pop
  // decision for the next cycle is made at the rising edge, with random stall
  // bursts while idling is allowed.
  initial begin : result_checker
    line_seg_t want;
    int        stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (expected_segments.size() == 0) begin
          $error("segment beat %0d arrived with no frame outstanding", segment_index_o);
          mismatches++;
        end else begin
          want = expected_segments.pop_front();
          check_field("clock_level",   want.clock_level,   clock_level_o);
          check_field("data_level",    want.data_level,    data_level_o);
          check_field("lines_driven",  want.lines_driven,  lines_driven_o);
          check_field("hold_us",       want.hold_us,       hold_us_o);
          check_field("segment_index", want.segment_index, segment_index_o);
          check_field("last_segment",  want.last_segment,  last_segment_o);
        end
      end
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Extremes of the byte, single set bits at either end, alternating patterns
  // and bytes chosen for both parity outcomes (even and odd counts of ones).
  task automatic test_directed_bytes();
    logic [7:0] cmds[12];
    int         i;
    cmds = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA,
             8'h0F, 8'hF0, 8'h03, 8'h07, 8'h7F, 8'hFE};
    for (i = 0; i < 12; i++) send_command(cmds[i]);
  endtask

  // Random bytes with idling on both sides, so gaps land on every segment.
  task automatic test_random_bytes(input int count);
    int i;
    for (i = 0; i < count; i++) send_command(8'($urandom_range(0, 255)));
  endtask

  // Last stretch: no idling anywhere, so the block runs at full rate with its
  // internal queue kept topped up.
  task automatic test_back_to_back(input int count);
    int i;
    idling_enabled = 1'b0;
    for (i = 0; i < count; i++) send_command(8'($urandom()));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_bytes();
    test_random_bytes(390);
    test_back_to_back(48);
    push <= 1'b0;

    // Drain every outstanding segment, then give any stray beat time to
    // surface before giving the verdict.
    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && expected_segments.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is roughly 450 frames of 37 segments, each
  // held up by the longest pop stall, i.e. about 4 ms; this allows several times that.
  initial begin : watchdog
    #(64'd20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/kcfs_pkg.sv
rtl/core/kcfs_front.sv
rtl/core/kcfs_queue.sv
rtl/core/kcfs_back.sv
rtl/core/keypad_command_frame_sender.sv
test/keypad_command_frame_sender_tb.sv
